// ----- rtl/core/rrbr_pkg.sv -----
// rrbr_pkg: shared types and codes of the round-robin budget ring
// no dependencies; imported by the controller, datapath and top level
package rrbr_pkg;

  // fixed field widths
  localparam int OPW  = 2;
  localparam int STW  = 2;
  localparam int IDW  = 16;
  localparam int QW   = 16;
  localparam int SW   = 22;
  localparam int TW   = 32;
  localparam int OCW  = 7;

  // operation codes
  localparam logic [OPW-1:0] OP_ADD    = 2'd0;
  localparam logic [OPW-1:0] OP_TURN   = 2'd1;
  localparam logic [OPW-1:0] OP_TOGGLE = 2'd2;
  localparam logic [OPW-1:0] OP_STATS  = 2'd3;

  // result status codes
  localparam logic [STW-1:0] ST_OK       = 2'd0;
  localparam logic [STW-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STW-1:0] ST_FULL     = 2'd2;
  localparam logic [STW-1:0] ST_NOTFOUND = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic           capture;
    logic           add;
    logic           scan_start;
    logic           scan_next;
    logic           turn_exec;
    logic           toggle_hit;
    logic           finish;
    logic [STW-1:0] fin_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [OPW-1:0] op;
    logic           empty;
    logic           full;
    logic           id_match;
    logic           scan_last;
  } sts_t;

endpackage

// ----- rtl/core/round_robin_budget_ring_unit.sv -----
// Round-robin budget ring: tasks with budgets served in turn by a quantum.
// An item is taken when start is high and busy low; its result appears on
// out_* for one cycle with out_valid high and cannot be held off. Add and
// stats finish in the dispatch state; a turn on a nonempty ring adds a turn
// state for the registered read of the head entry, and a toggle searches from
// the head until the id matches or the last task is passed, reading one ring
// entry per cycle through the single read port of the task store. The store
// holds no valid bits and needs no clearing pass after reset. The drain
// quantum is written through cfg_valid/cfg_ready (always ready); the user
// must write it only while the unit is idle; the block does not enforce it.
// depends on rrbr_pkg, rrbr_ctrl, rrbr_dpath and rrbr_ram
module round_robin_budget_ring_unit #(
  parameter int RING_DEPTH  = 64,
  parameter int BUDGET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [rrbr_pkg::OPW-1:0]    in_operation,
  input  logic [15:0]                 in_budget,
  input  logic [15:0]                 in_target_id,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rrbr_pkg::QW-1:0]     cfg_drain_quantum,
  output logic                        out_valid,
  output logic [rrbr_pkg::STW-1:0]    out_status,
  output logic [rrbr_pkg::IDW-1:0]    out_assigned_id,
  output logic                        out_removed,
  output logic [rrbr_pkg::IDW-1:0]    out_removed_id,
  output logic [rrbr_pkg::OCW-1:0]    out_task_count,
  output logic [rrbr_pkg::SW-1:0]     out_budget_sum,
  output logic [rrbr_pkg::TW-1:0]     out_tick_count
);
  import rrbr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  rrbr_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .sts  (sts),
    .cmd  (cmd)
  );

  rrbr_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .BUDGET_BITS(BUDGET_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_budget        (in_budget),
    .in_target_id     (in_target_id),
    .cfg_valid        (cfg_valid),
    .cfg_drain_quantum(cfg_drain_quantum),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_assigned_id  (out_assigned_id),
    .out_removed      (out_removed),
    .out_removed_id   (out_removed_id),
    .out_task_count   (out_task_count),
    .out_budget_sum   (out_budget_sum),
    .out_tick_count   (out_tick_count)
  );

endmodule

// ----- rtl/core/rrbr_ram.sv -----
// rrbr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module rrbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/core/rrbr_ctrl.sv -----
// rrbr_ctrl: sequencing state machine of the budget ring
// depends on rrbr_pkg (command and status structs, codes)
module rrbr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  rrbr_pkg::sts_t sts,
  output rrbr_pkg::cmd_t cmd
);
  import rrbr_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_TURN = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.op)
          OP_ADD: begin
            cmd.finish = 1'b1;
            if (sts.full) begin
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.add        = 1'b1;
              cmd.fin_status = ST_OK;
            end
            state_nxt = S_IDLE;
          end
          OP_TURN: begin
            if (sts.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_EMPTY;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_TURN;
            end
          end
          OP_TOGGLE: begin
            if (sts.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_EMPTY;
              state_nxt      = S_IDLE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_CHK;
            end
          end
          default: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_OK;
            state_nxt      = S_IDLE;
          end
        endcase
      end
      S_TURN: begin
        cmd.turn_exec  = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        if (sts.id_match) begin
          cmd.toggle_hit = 1'b1;
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          state_nxt      = S_IDLE;
        end else if (sts.scan_last) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
    endcase
  end

endmodule

// ----- rtl/core/rrbr_dpath.sv -----
// rrbr_dpath: ring pointers, totals, task store and result registers
// depends on rrbr_pkg and rrbr_ram
module rrbr_dpath #(
  parameter int RING_DEPTH  = 64,
  parameter int BUDGET_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rrbr_pkg::OPW-1:0]    in_operation,
  input  logic [15:0]                 in_budget,
  input  logic [15:0]                 in_target_id,
  input  logic                        cfg_valid,
  input  logic [rrbr_pkg::QW-1:0]     cfg_drain_quantum,
  input  rrbr_pkg::cmd_t              cmd,
  output rrbr_pkg::sts_t              sts,
  output logic                        out_valid,
  output logic [rrbr_pkg::STW-1:0]    out_status,
  output logic [rrbr_pkg::IDW-1:0]    out_assigned_id,
  output logic                        out_removed,
  output logic [rrbr_pkg::IDW-1:0]    out_removed_id,
  output logic [rrbr_pkg::OCW-1:0]    out_task_count,
  output logic [rrbr_pkg::SW-1:0]     out_budget_sum,
  output logic [rrbr_pkg::TW-1:0]     out_tick_count
);
  import rrbr_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int DW = BUDGET_BITS;
  localparam int EW = IDW + DW + QW + 1;
  localparam int IW = (DW > 16) ? DW : 16;
  localparam int MW = (DW > QW) ? DW : QW;

  // captured item and configuration
  logic [OPW-1:0] op_r;
  logic [15:0]    bud_r;
  logic [IDW-1:0] tgt_r;
  logic [QW-1:0]  quantum_r;

  // ring state
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  occ_r, occ_nxt;
  logic [IDW-1:0] nid_r, nid_nxt;
  logic [TW-1:0]  tick_r, tick_nxt;
  logic [SW-1:0]  sum_r, sum_nxt;
  logic [AW-1:0]  ptr_r;
  logic [CW-1:0]  idx_r;

  // result registers
  logic           out_valid_r;
  logic [STW-1:0] out_status_r;
  logic [IDW-1:0] out_assigned_r, assigned_nxt;
  logic           out_removed_r, removed_nxt;
  logic [IDW-1:0] out_removed_id_r, removed_id_nxt;
  logic [OCW-1:0] out_count_r;
  logic [SW-1:0]  out_sum_r;
  logic [TW-1:0]  out_tick_r;

  // store ports
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [EW-1:0]  wdata, rdata;

  // derived addresses
  logic [CW:0]    tail_sum;
  logic [AW-1:0]  tail, head_inc, ptr_inc;

  // fields of the entry read back
  logic [IDW-1:0] e_id;
  logic [DW-1:0]  e_bud;
  logic [QW-1:0]  e_drn;
  logic           e_pau;

  // new-task and turn arithmetic
  logic [IW-1:0]  bud_ext, bmax_ext, bud_sat_ext;
  logic [DW-1:0]  bud_sat, use_amt, bud_left;
  logic [QW-1:0]  new_drain;
  logic [MW-1:0]  d_ext, b_ext, use_ext;

  rrbr_ram #(
    .WIDTH(EW),
    .DEPTH(RING_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // ring address arithmetic, one wrap correction each
  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(occ_r);
    tail     = (tail_sum >= (CW+1)'(RING_DEPTH)) ?
               AW'(tail_sum - (CW+1)'(RING_DEPTH)) : AW'(tail_sum);
    head_inc = (head_r == AW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
    ptr_inc  = (ptr_r == AW'(RING_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  end

  assign raddr = cmd.scan_next ? ptr_inc : head_r;

  // entry unpacking
  assign e_id  = rdata[IDW-1:0];
  assign e_bud = rdata[IDW +: DW];
  assign e_drn = rdata[IDW+DW +: QW];
  assign e_pau = rdata[EW-1];

  // new task: saturated budget and nonzero drain
  always_comb begin
    bud_ext     = IW'(bud_r);
    bmax_ext    = IW'({DW{1'b1}});
    bud_sat_ext = (bud_ext > bmax_ext) ? bmax_ext : bud_ext;
    bud_sat     = DW'(bud_sat_ext);
    new_drain   = (quantum_r == '0) ? QW'(1) : quantum_r;
  end

  // served task: drain taken is the smaller of drain and budget
  always_comb begin
    d_ext    = (e_drn == '0) ? MW'(1) : MW'(e_drn);
    b_ext    = MW'(e_bud);
    use_ext  = (d_ext <= b_ext) ? d_ext : b_ext;
    use_amt  = DW'(use_ext);
    bud_left = e_bud - use_amt;
  end

  // next state of the ring and store write
  always_comb begin
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    nid_nxt        = nid_r;
    tick_nxt       = tick_r;
    sum_nxt        = sum_r;
    assigned_nxt   = '0;
    removed_nxt    = 1'b0;
    removed_id_nxt = '0;
    we             = 1'b0;
    waddr          = tail;
    wdata          = {1'b0, new_drain, bud_sat, nid_r};
    if (cmd.add) begin
      we           = 1'b1;
      occ_nxt      = occ_r + 1'b1;
      sum_nxt      = sum_r + SW'(bud_sat);
      assigned_nxt = nid_r;
      nid_nxt      = nid_r + 1'b1;
    end
    if (cmd.turn_exec) begin
      tick_nxt = tick_r + 1'b1;
      head_nxt = head_inc;
      if (e_pau) begin
        we    = 1'b1;
        wdata = rdata;
      end else begin
        sum_nxt = sum_r - SW'(use_amt);
        if (bud_left == '0) begin
          removed_nxt    = 1'b1;
          removed_id_nxt = e_id;
          occ_nxt        = occ_r - 1'b1;
        end else begin
          we    = 1'b1;
          wdata = {e_pau, e_drn, bud_left, e_id};
        end
      end
    end
    if (cmd.toggle_hit) begin
      we    = 1'b1;
      waddr = ptr_r;
      wdata = {~e_pau, e_drn, e_bud, e_id};
    end
  end

  // status to the controller
  always_comb begin
    sts.op        = op_r;
    sts.empty     = (occ_r == '0);
    sts.full      = (occ_r == CW'(RING_DEPTH));
    sts.id_match  = (e_id == tgt_r);
    sts.scan_last = ((idx_r + 1'b1) == occ_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QW'(1);
      head_r      <= '0;
      occ_r       <= '0;
      nid_r       <= IDW'(1);
      tick_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        quantum_r <= cfg_drain_quantum;
      end
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      nid_r       <= nid_nxt;
      tick_r      <= tick_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  // item capture, scan pointer and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      bud_r <= in_budget;
      tgt_r <= in_target_id;
    end
    if (cmd.scan_start) begin
      ptr_r <= head_r;
      idx_r <= '0;
    end else if (cmd.scan_next) begin
      ptr_r <= ptr_inc;
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.finish) begin
      out_status_r     <= cmd.fin_status;
      out_assigned_r   <= assigned_nxt;
      out_removed_r    <= removed_nxt;
      out_removed_id_r <= removed_id_nxt;
      out_count_r      <= OCW'(occ_nxt);
      out_sum_r        <= sum_nxt;
      out_tick_r       <= tick_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_assigned_r;
  assign out_removed     = out_removed_r;
  assign out_removed_id  = out_removed_id_r;
  assign out_task_count  = out_count_r;
  assign out_budget_sum  = out_sum_r;
  assign out_tick_count  = out_tick_r;

`ifndef SYNTHESIS
  // occupancy never exceeds the ring
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(RING_DEPTH))
    else $error("occupancy beyond ring depth");

  // head pointer stays inside the ring
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(RING_DEPTH - 1))
    else $error("head index out of range");

  // the scan never steps past the last occupied entry
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> (idx_r + 1'b1) < occ_r)
    else $error("scan past occupancy");

  // a full report only comes from a full ring, which stays full
  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |-> occ_r == CW'(RING_DEPTH))
    else $error("full status on a ring with room");
`endif

endmodule
